@@ rtl/afk_pkg.sv @@
`default_nettype none
package afk_pkg;

   localparam int TW = 27;
   localparam int ZW = 24;
   localparam int CORDIC_STEPS = 16;
   localparam int CST = CORDIC_STEPS + 2;
   localparam int POST_STAGES = 6;
   localparam int NST = CST + POST_STAGES;
   localparam int POSITION_FRAC_BITS = 14;

   localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
   localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [TW-1:0] CORDIC_GAIN = 27'sd10188014;

   localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396,
      24'sd65451, 24'sd32757, 24'sd16383, 24'sd8192,
      24'sd4096, 24'sd2048, 24'sd1024, 24'sd512,
      24'sd256, 24'sd128, 24'sd64, 24'sd32
   };

   localparam logic REG_D2 = 1'b0;
   localparam logic REG_D4 = 1'b1;

   localparam logic [14:0] D2_RESET = 15'd16417;
   localparam logic [14:0] D4_RESET = 15'd18276;

   function automatic logic signed [16:0] sat_pos(input logic signed [52:0] v);
      logic signed [16:0] r;
      if (v > 53'sd65535) begin
         r = 17'sd65535;
      end else if (v < -53'sd65536) begin
         r = -17'sd65536;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/afk_req_if.sv @@
`default_nettype none
interface afk_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] base_angle;
   logic signed [15:0] shoulder_angle;
   logic signed [15:0] elbow_angle;

   modport source (output valid, base_angle, shoulder_angle, elbow_angle, input ready);
   modport sink (input valid, base_angle, shoulder_angle, elbow_angle, output ready);
endinterface
`default_nettype wire

@@ rtl/afk_rsp_if.sv @@
`default_nettype none
interface afk_rsp_if;
   logic valid;
   logic ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

@@ rtl/afk_cordic.sv @@
`default_nettype none
module afk_cordic
   import afk_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic [CST-1:0]        stage_en,
   input  wire logic signed [15:0]    angle,
   output logic signed [TW-1:0]       sin_out,
   output logic signed [TW-1:0]       cos_out
);

   logic signed [ZW-1:0] z_raw;
   logic signed [ZW-1:0] z0_in;
   logic                 flip0_in;
   logic signed [TW-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [TW-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0] z_ff [CORDIC_STEPS+1];
   logic                 flip_ff [CORDIC_STEPS+1];
   logic signed [TW-1:0] x_in [CORDIC_STEPS+1];
   logic signed [TW-1:0] y_in [CORDIC_STEPS+1];
   logic signed [ZW-1:0] z_in [CORDIC_STEPS+1];
   logic signed [TW-1:0] sin_ff;
   logic signed [TW-1:0] cos_ff;

   always_comb begin
      z_raw = {angle[15], angle, 7'b0};
      z0_in = z_raw;
      flip0_in = 1'b0;
      if (z_raw > HALF_PI_Q20) begin
         z0_in = z_raw - PI_Q20;
         flip0_in = 1'b1;
      end else if (z_raw < -HALF_PI_Q20) begin
         z0_in = z_raw + PI_Q20;
         flip0_in = 1'b1;
      end
   end

   always_comb begin
      x_in[0] = CORDIC_GAIN;
      y_in[0] = '0;
      z_in[0] = z0_in;
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
         if (!z_ff[k-1][ZW-1]) begin
            x_in[k] = x_ff[k-1] - (y_ff[k-1] >>> (k - 1));
            y_in[k] = y_ff[k-1] + (x_ff[k-1] >>> (k - 1));
            z_in[k] = z_ff[k-1] - ATAN_TAB[k-1];
         end else begin
            x_in[k] = x_ff[k-1] + (y_ff[k-1] >>> (k - 1));
            y_in[k] = y_ff[k-1] - (x_ff[k-1] >>> (k - 1));
            z_in[k] = z_ff[k-1] + ATAN_TAB[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x_ff[0] <= x_in[0];
         y_ff[0] <= y_in[0];
         z_ff[0] <= z_in[0];
         flip_ff[0] <= flip0_in;
      end
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
         if (stage_en[k]) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            flip_ff[k] <= flip_ff[k-1];
         end
      end
      if (stage_en[CST-1]) begin
         cos_ff <= flip_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];
         sin_ff <= flip_ff[CORDIC_STEPS] ? -y_ff[CORDIC_STEPS] : y_ff[CORDIC_STEPS];
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire

@@ rtl/arm_forward_kinematics.sv @@
`default_nettype none
// Computes the arm tip position from three joint angles, one item per clock cycle
// while the output side does not stall. Each item passes through 24 register stages:
// one for angle reduction, sixteen CORDIC rotation steps run in three parallel lanes,
// one for the quadrant sign, and six for the multiply, round and saturate path; each
// result is presented from the last of these stages. Every stage holds its own valid
// bit, so bubbles close up under backpressure. The link lengths are read live and
// should only be written while no item is in flight.
module arm_forward_kinematics
   import afk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   afk_req_if.sink          req_if,
   afk_rsp_if.source        rsp_if,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int PA = CST;

   logic [14:0] d2_ff;
   logic [14:0] d4_ff;
   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   logic signed [TW-1:0] s0, c0, s1, c1, s2, c2;

   logic signed [41:0] pa_ff, pc_ff;
   logic signed [TW-1:0] a_c0_ff, a_s0_ff, a_c1_ff, a_s1_ff;
   logic signed [41:0] ra, rc, y1_full;

   logic signed [25:0] a_ff;
   logic signed [26:0] y1_ff;
   logic signed [TW-1:0] b_c0_ff, b_s0_ff, b_c1_ff, b_s1_ff;

   logic signed [52:0] x1p_ff, zp_ff;
   logic signed [26:0] c_y1_ff;
   logic signed [TW-1:0] c_c0_ff, c_s0_ff;
   logic signed [52:0] x1_full, zr_full;

   logic signed [24:0] x1_ff;
   logic signed [26:0] d_y1_ff;
   logic signed [16:0] d_z_ff;
   logic signed [TW-1:0] d_c0_ff, d_s0_ff;

   logic signed [51:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;
   logic signed [16:0] e_z_ff;
   logic signed [52:0] sx_full, sy_full;

   logic signed [16:0] px_ff, py_ff, pz_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_ff <= D2_RESET;
         d4_ff <= D4_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_D2: d2_ff <= csr_pwdata[14:0];
            REG_D4: d4_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_D2: csr_prdata = {17'b0, d2_ff};
         REG_D4: csr_prdata = {17'b0, d4_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_if.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_if.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_if.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   afk_cordic u_cordic0 (
      .clock(clock), .stage_en(en[CST-1:0]), .angle(req_if.base_angle),
      .sin_out(s0), .cos_out(c0)
   );
   afk_cordic u_cordic1 (
      .clock(clock), .stage_en(en[CST-1:0]), .angle(req_if.shoulder_angle),
      .sin_out(s1), .cos_out(c1)
   );
   afk_cordic u_cordic2 (
      .clock(clock), .stage_en(en[CST-1:0]), .angle(req_if.elbow_angle),
      .sin_out(s2), .cos_out(c2)
   );

   always_comb begin
      ra = (pa_ff + 42'sd32768) >>> 16;
      rc = (pc_ff + 42'sd32768) >>> 16;
      y1_full = -rc - $signed({19'b0, d2_ff, 8'b0});
      x1_full = (x1p_ff + 53'sd8388608) >>> 24;
      zr_full = (zp_ff + 53'sd2147483648) >>> 32;
      sx_full = (53'(p_cx_ff) - 53'(p_sy_ff) + 53'sd2147483648) >>> 32;
      sy_full = (53'(p_sx_ff) + 53'(p_cy_ff) + 53'sd2147483648) >>> 32;
   end

   always_ff @(posedge clock) begin
      if (en[PA]) begin
         pa_ff <= 42'($signed({1'b0, d4_ff}) * s2);
         pc_ff <= 42'($signed({1'b0, d4_ff}) * c2);
         a_c0_ff <= c0;
         a_s0_ff <= s0;
         a_c1_ff <= c1;
         a_s1_ff <= s1;
      end
      if (en[PA+1]) begin
         a_ff <= ra[25:0];
         y1_ff <= y1_full[26:0];
         b_c0_ff <= a_c0_ff;
         b_s0_ff <= a_s0_ff;
         b_c1_ff <= a_c1_ff;
         b_s1_ff <= a_s1_ff;
      end
      if (en[PA+2]) begin
         x1p_ff <= 53'(b_c1_ff * a_ff);
         zp_ff <= 53'(b_s1_ff * a_ff);
         c_y1_ff <= y1_ff;
         c_c0_ff <= b_c0_ff;
         c_s0_ff <= b_s0_ff;
      end
      if (en[PA+3]) begin
         x1_ff <= x1_full[24:0];
         d_z_ff <= sat_pos(zr_full);
         d_y1_ff <= c_y1_ff;
         d_c0_ff <= c_c0_ff;
         d_s0_ff <= c_s0_ff;
      end
      if (en[PA+4]) begin
         p_cx_ff <= 52'(d_c0_ff * x1_ff);
         p_sy_ff <= 52'(d_s0_ff * d_y1_ff);
         p_sx_ff <= 52'(d_s0_ff * x1_ff);
         p_cy_ff <= 52'(d_c0_ff * d_y1_ff);
         e_z_ff <= d_z_ff;
      end
      if (en[PA+5]) begin
         px_ff <= sat_pos(sx_full);
         py_ff <= sat_pos(sy_full);
         pz_ff <= e_z_ff;
      end
   end

   assign rsp_if.valid = v_ff[NST-1];
   assign rsp_if.pos_x = px_ff;
   assign rsp_if.pos_y = py_ff;
   assign rsp_if.pos_z = pz_ff;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb
   import afk_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH = 24;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [2:0] ADDR_D2 = 3'd0;
   localparam logic [2:0] ADDR_D4 = 3'd4;

   typedef struct packed {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
   } tip_pos_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   afk_req_if req_if ();
   afk_rsp_if rsp_if ();

   arm_forward_kinematics dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   longint d2_len = D2_RESET;
   longint d4_len = D4_RESET;
   tip_pos_type expected_tips[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   longint cycle_count = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.base_angle = '0;
      req_if.shoulder_angle = '0;
      req_if.elbow_angle = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_sh(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic void joint_sincos(logic signed [15:0] q, output longint s,
                                        output longint c);
      longint z, x, y, dx, dy;
      bit flip;
      flip = 1'b0;
      z = longint'(q) * 128;
      if (z > HALF_PI_Q20) begin
         z -= PI_Q20;
         flip = 1'b1;
      end else if (z < -HALF_PI_Q20) begin
         z += PI_Q20;
         flip = 1'b1;
      end
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ATAN_TAB[i];
         end else begin
            x += dx;
            y -= dy;
            z += ATAN_TAB[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endfunction

   function automatic logic signed [16:0] clamp_pos(longint v);
      if (v > 65535) return 17'sd65535;
      if (v < -65536) return -17'sd65536;
      return v[16:0];
   endfunction

   function automatic tip_pos_type arm_tip(logic signed [15:0] q0, logic signed [15:0] q1,
                                           logic signed [15:0] q2);
      longint s0, c0, s1, c1, s2, c2, a, x1, y1;
      tip_pos_type t;
      joint_sincos(q0, s0, c0);
      joint_sincos(q1, s1, c1);
      joint_sincos(q2, s2, c2);
      a = round_sh(d4_len * s2, 16);
      x1 = round_sh(c1 * a, 24);
      y1 = -round_sh(d4_len * c2, 16) - d2_len * 256;
      t.x = clamp_pos(round_sh(c0 * x1 - s0 * y1, 32));
      t.y = clamp_pos(round_sh(s0 * x1 + c0 * y1, 32));
      t.z = clamp_pos(round_sh(s1 * a, 32));
      return t;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      tip_pos_type exp_tip;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_tips.size() == 0) begin
            $error("unexpected item x=%0d y=%0d z=%0d", rsp_if.pos_x, rsp_if.pos_y,
                   rsp_if.pos_z);
            fail_count++;
         end else begin
            exp_tip = expected_tips.pop_front();
            if (rsp_if.pos_x !== exp_tip.x) begin
               $error("pos_x expected %0d actual %0d", exp_tip.x, rsp_if.pos_x);
               fail_count++;
            end
            if (rsp_if.pos_y !== exp_tip.y) begin
               $error("pos_y expected %0d actual %0d", exp_tip.y, rsp_if.pos_y);
               fail_count++;
            end
            if (rsp_if.pos_z !== exp_tip.z) begin
               $error("pos_z expected %0d actual %0d", exp_tip.z, rsp_if.pos_z);
               fail_count++;
            end
         end
      end
   end

   task automatic send_joints(logic signed [15:0] q0, logic signed [15:0] q1,
                              logic signed [15:0] q2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.base_angle <= q0;
      req_if.shoulder_angle <= q1;
      req_if.elbow_angle <= q2;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_tips.push_back(arm_tip(q0, q1, q2));
   endtask

   task automatic drain_pipe();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_tips.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_link(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_D2) d2_len = value & 32'h7FFF;
      else d4_len = value & 32'h7FFF;
   endtask

   function automatic logic signed [15:0] any_angle();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($urandom_range(51472) - 25736);
   endfunction

   task automatic test_angle_extremes();
      logic signed [15:0] corner[8] = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd25736,
                                        -16'sd25736, 16'sd12868, -16'sd12868, 16'sd12869};
      for (int i = 0; i < 8; i++) send_joints(corner[i], corner[(i + 3) % 8],
                                              corner[(i + 5) % 8]);
      send_joints(16'shFFFF, 16'sh5555, 16'shAAAA);
      drain_pipe();
   endtask

   task automatic test_link_settings();
      logic [31:0] pairs[4][2] = '{'{32'h0, 32'h0}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
                                   '{32'h7FFF, 32'h0}, '{32'h0, 32'h7FFF}};
      for (int p = 0; p < 4; p++) begin
         write_link(ADDR_D2, pairs[p][0]);
         write_link(ADDR_D4, pairs[p][1]);
         send_joints(16'sd0, 16'sd0, 16'sd0);
         send_joints(16'sd12868, 16'sd12868, 16'sd12868);
         send_joints(-16'sd25736, 16'sh7FFF, 16'sh8000);
         drain_pipe();
      end
   endtask

   task automatic test_random_phase(int n_items);
      write_link(ADDR_D2, $urandom);
      write_link(ADDR_D4, $urandom);
      for (int i = 0; i < n_items; i++) send_joints(any_angle(), any_angle(), any_angle());
      drain_pipe();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_angle_extremes();
      test_link_settings();
      send_idle_pct = 35;
      recv_idle_pct = 76;
      for (int k = 0; k < 3; k++) test_random_phase(200);
      send_idle_pct = 76;
      recv_idle_pct = 35;
      for (int k = 0; k < 3; k++) test_random_phase(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 2; k++) test_random_phase(275);
      write_link(ADDR_D2, 32'd16417);
      write_link(ADDR_D4, 32'd18276);
      test_random_phase(0);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
